FILE: rtl/tpp_pkg.sv
// Shared types, widths and microcode for the trapezoid position profile.
// Used by the channel interfaces, the multiply-accumulate unit and the top level.
package tpp_pkg;

  localparam int unsigned CFG_W     = 40;
  localparam int unsigned TLIM_W    = 32;
  localparam int unsigned ELAPSED_W = 33;
  localparam int unsigned DT_W      = 16;
  localparam int unsigned POS_W     = 42;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned MUL_W     = 22;
  localparam int unsigned OPND_W    = 2 * MUL_W;
  localparam int unsigned PP_W      = 2 * MUL_W;
  localparam int unsigned ACC_W     = 2 * OPND_W;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [STEP_W-1:0] STEP_EMIT = STEP_W'(20);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET     = 3'd0,
    REG_FINAL_VEL  = 3'd1,
    REG_ACCEL      = 3'd2,
    REG_VEL_LIMIT  = 3'd3,
    REG_TIME_LIMIT = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {OPA_VF, OPA_ACCEL2, OPA_VMAG, OPA_ACCEL} opa_e;
  typedef enum logic [1:0] {OPB_VF, OPB_REM, OPB_VMAG, OPB_DT} opb_e;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_e;
  typedef enum logic [2:0] {ACT_NONE, ACT_DECIDE, ACT_VEL, ACT_POS, ACT_EMIT} act_e;
  typedef enum logic [1:0] {SEQ_NEXT, SEQ_SKIP_IF_IDLE, SEQ_END} seq_e;

  // Accumulator control: operation and shift of the partial product in MUL_W steps
  typedef struct packed {
    acc_op_e    op;
    logic [1:0] sh;
  } macc_ctrl_t;

  typedef struct packed {
    opa_e       a_sel;
    logic       a_hi;
    opb_e       b_sel;
    logic       b_hi;
    macc_ctrl_t acc;
    act_e       act;
    seq_e       seq;
  } uword_t;

  function automatic uword_t uw(opa_e a, logic ah, opb_e b, logic bh,
                                acc_op_e op, logic [1:0] sh, act_e act, seq_e seq);
    uword_t w;
    w.a_sel  = a;
    w.a_hi   = ah;
    w.b_sel  = b;
    w.b_hi   = bh;
    w.acc.op = op;
    w.acc.sh = sh;
    w.act    = act;
    w.seq    = seq;
    return w;
  endfunction

  // Control store. The multiplier operands of a step produce a partial product
  // that the accumulator field of the following step consumes.
  //   steps 0..12 : D = vf^2 + 2a*rem - |v|^2, accelerate when D > 0
  //   steps 12..15: a*dt, velocity update
  //   steps 16..19: |v|*dt, setpoint update
  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    case (step)
      5'd0:  return uw(OPA_VF,     1'b0, OPB_VF,   1'b0, ACC_HOLD, 2'd0, ACT_NONE,
                       SEQ_SKIP_IF_IDLE);
      5'd1:  return uw(OPA_VF,     1'b0, OPB_VF,   1'b1, ACC_LOAD, 2'd0, ACT_NONE, SEQ_NEXT);
      5'd2:  return uw(OPA_VF,     1'b1, OPB_VF,   1'b0, ACC_ADD,  2'd1, ACT_NONE, SEQ_NEXT);
      5'd3:  return uw(OPA_VF,     1'b1, OPB_VF,   1'b1, ACC_ADD,  2'd1, ACT_NONE, SEQ_NEXT);
      5'd4:  return uw(OPA_ACCEL2, 1'b0, OPB_REM,  1'b0, ACC_ADD,  2'd2, ACT_NONE, SEQ_NEXT);
      5'd5:  return uw(OPA_ACCEL2, 1'b0, OPB_REM,  1'b1, ACC_ADD,  2'd0, ACT_NONE, SEQ_NEXT);
      5'd6:  return uw(OPA_ACCEL2, 1'b1, OPB_REM,  1'b0, ACC_ADD,  2'd1, ACT_NONE, SEQ_NEXT);
      5'd7:  return uw(OPA_ACCEL2, 1'b1, OPB_REM,  1'b1, ACC_ADD,  2'd1, ACT_NONE, SEQ_NEXT);
      5'd8:  return uw(OPA_VMAG,   1'b0, OPB_VMAG, 1'b0, ACC_ADD,  2'd2, ACT_NONE, SEQ_NEXT);
      5'd9:  return uw(OPA_VMAG,   1'b0, OPB_VMAG, 1'b1, ACC_SUB,  2'd0, ACT_NONE, SEQ_NEXT);
      5'd10: return uw(OPA_VMAG,   1'b1, OPB_VMAG, 1'b0, ACC_SUB,  2'd1, ACT_NONE, SEQ_NEXT);
      5'd11: return uw(OPA_VMAG,   1'b1, OPB_VMAG, 1'b1, ACC_SUB,  2'd1, ACT_NONE, SEQ_NEXT);
      5'd12: return uw(OPA_ACCEL,  1'b0, OPB_DT,   1'b0, ACC_SUB,  2'd2, ACT_NONE, SEQ_NEXT);
      5'd13: return uw(OPA_ACCEL,  1'b1, OPB_DT,   1'b0, ACC_LOAD, 2'd0, ACT_DECIDE, SEQ_NEXT);
      5'd14: return uw(OPA_VMAG,   1'b0, OPB_DT,   1'b0, ACC_ADD,  2'd1, ACT_NONE, SEQ_NEXT);
      5'd15: return uw(OPA_VMAG,   1'b0, OPB_DT,   1'b0, ACC_HOLD, 2'd0, ACT_VEL,  SEQ_NEXT);
      5'd16: return uw(OPA_VMAG,   1'b0, OPB_DT,   1'b0, ACC_HOLD, 2'd0, ACT_NONE, SEQ_NEXT);
      5'd17: return uw(OPA_VMAG,   1'b1, OPB_DT,   1'b0, ACC_LOAD, 2'd0, ACT_NONE, SEQ_NEXT);
      5'd18: return uw(OPA_VMAG,   1'b0, OPB_DT,   1'b0, ACC_ADD,  2'd1, ACT_NONE, SEQ_NEXT);
      5'd19: return uw(OPA_VMAG,   1'b0, OPB_DT,   1'b0, ACC_HOLD, 2'd0, ACT_POS,  SEQ_NEXT);
      default: return uw(OPA_VF,   1'b0, OPB_VF,   1'b0, ACC_HOLD, 2'd0, ACT_EMIT, SEQ_END);
    endcase
  endfunction

endpackage

FILE: rtl/tpp_in_if.sv
// Input channel of the trapezoid position profile: valid/ready plus command and time step.
// Depends on tpp_pkg.
interface tpp_in_if;
  import tpp_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [DT_W-1:0]   time_step;

  modport source (output valid, command, time_step, input ready);
  modport sink   (input valid, command, time_step, output ready);
endinterface

FILE: rtl/tpp_out_if.sv
// Output channel of the trapezoid position profile: valid/ready plus wheel setpoints.
// Depends on tpp_pkg.
interface tpp_out_if;
  import tpp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] left_position;
  logic signed [POS_W-1:0] right_position;
  logic                    done_res;

  modport source (output valid, left_position, right_position, done_res, input ready);
  modport sink   (input valid, left_position, right_position, done_res, output ready);
endinterface

FILE: rtl/tpp_macc.sv
// Shared 22x22 multiplier with a registered partial product and a shifting accumulator.
// Depends on tpp_pkg.
module tpp_macc (
  input  logic                        clk_i,
  input  logic [tpp_pkg::MUL_W-1:0]   mul_a_i,
  input  logic [tpp_pkg::MUL_W-1:0]   mul_b_i,
  input  tpp_pkg::macc_ctrl_t         ctrl_i,
  output logic [tpp_pkg::ACC_W-1:0]   acc_o
);
  import tpp_pkg::*;

  logic [PP_W-1:0]  pp_q;
  logic [ACC_W-1:0] acc_q, acc_d, pp_sh;

  always_comb begin
    pp_sh = ACC_W'(pp_q) << (ctrl_i.sh * MUL_W);
    case (ctrl_i.op)
      ACC_LOAD: acc_d = pp_sh;
      ACC_ADD:  acc_d = acc_q + pp_sh;
      ACC_SUB:  acc_d = acc_q - pp_sh;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pp_q  <= mul_a_i * mul_b_i;
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;
endmodule

FILE: rtl/trapezoid_position_profile.sv
// Top level of the trapezoid position profile: config registers, profile state and
// microcode sequencer. Depends on tpp_pkg, tpp_in_if, tpp_out_if and tpp_macc.
//
//  channel   | dir | transfer when         | payload
//  ----------+-----+-----------------------+-------------------------------------------
//  in_i      | in  | valid && ready        | command, time_step
//  out_o     | out | valid && ready        | left_position, right_position, done_res
//  cfg       | in  | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// A moving tick runs the 21-step control program, and the one shared 22x22 multiplier
// builds the stopping-distance products, a*dt and |v|*dt in halves.
// A start or a tick on a finished profile skips to the last step.
// One item in work at a time; a result held by a stalled sink holds the last step.
// Reset is asynchronous: it clears the profile state and loads the register defaults.
module trapezoid_position_profile (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tpp_pkg::CFG_W-1:0]      cfg_data_i,
  tpp_in_if.sink                         in_i,
  tpp_out_if.source                      out_o
);
  import tpp_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0]  tgt_q, vf_q, accel_q, vlim_q;
  logic [TLIM_W-1:0] tlim_q;

  // Profile state
  logic signed [POS_W-1:0] sp_q, v_q;
  logic [ELAPSED_W-1:0]    elapsed_q;
  logic                    speed_up_q;

  // Sequencer and held item
  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic              cmd_q;
  logic [DT_W-1:0]   dt_q;

  // Result register
  logic                    out_valid_q;
  logic signed [POS_W-1:0] left_q, right_q;
  logic                    done_q;

  uword_t            uw_cur;
  macc_ctrl_t        macc_ctrl;
  logic [ACC_W-1:0]  acc;
  logic [OPND_W-1:0] opa_word, opb_word;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [POS_W-1:0]  vmag, rem;
  logic              done, idle_item, out_free, accept, emit;
  logic [CFG_W-1:0]  dv;
  logic [POS_W:0]    v_dec;
  logic [POS_W-1:0]  v_next;
  logic [POS_W+16:0] prod_mag, prod_sgn;
  logic [POS_W:0]    delta;
  logic [POS_W+1:0]  sp_sum;
  logic [POS_W-1:0]  sp_next;

  localparam logic [POS_W+1:0] SP_MIN = 44'hE00_0000_0001;

  assign uw_cur = ucode(step_q);

  always_comb begin
    vmag = v_q[POS_W-1] ? POS_W'(-v_q) : POS_W'(v_q);
    rem  = {2'b00, tgt_q} - POS_W'(sp_q);
    done = !(($signed(sp_q) < $signed({2'b00, tgt_q})) &&
             (elapsed_q < {1'b0, tlim_q}));
    idle_item = !cmd_q || done;
    out_free  = !out_valid_q || out_o.ready;
    accept    = in_i.valid && !busy_q;
    // load the result register from the last step once it is free
    emit      = busy_q && (uw_cur.act == ACT_EMIT) && out_free;

    // Operand selection, one 22-bit half per side
    case (uw_cur.a_sel)
      OPA_VF:     opa_word = OPND_W'(vf_q);
      OPA_ACCEL2: opa_word = OPND_W'({accel_q, 1'b0});
      OPA_VMAG:   opa_word = OPND_W'(vmag);
      default:    opa_word = OPND_W'(accel_q);
    endcase
    case (uw_cur.b_sel)
      OPB_VF:   opb_word = OPND_W'(vf_q);
      OPB_REM:  opb_word = OPND_W'(rem);
      OPB_VMAG: opb_word = OPND_W'(vmag);
      default:  opb_word = OPND_W'(dt_q);
    endcase
    mul_a = uw_cur.a_hi ? opa_word[OPND_W-1:MUL_W] : opa_word[MUL_W-1:0];
    mul_b = uw_cur.b_hi ? opb_word[OPND_W-1:MUL_W] : opb_word[MUL_W-1:0];

    macc_ctrl.op = busy_q ? uw_cur.acc.op : ACC_HOLD;
    macc_ctrl.sh = uw_cur.acc.sh;

    // Velocity: clamp to the limit or add a*dt when speeding up, else subtract and
    // saturate at the most negative value
    dv    = acc[CFG_W+FRAC_W-1:FRAC_W];
    v_dec = {v_q[POS_W-1], v_q} - {3'b000, dv};
    if (speed_up_q) begin
      if ($signed({2'b00, vlim_q}) <= v_q) v_next = {2'b00, vlim_q};
      else                                 v_next = POS_W'(v_q) + {2'b00, dv};
    end else if (v_dec[POS_W] && !v_dec[POS_W-1]) begin
      v_next = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      v_next = v_dec[POS_W-1:0];
    end

    // Setpoint: floor(v*dt / 2^16), clamp above to the target and below so the
    // negated setpoint still fits
    prod_mag = {1'b0, acc[POS_W+DT_W-1:0]};
    prod_sgn = v_q[POS_W-1] ? -prod_mag : prod_mag;
    delta    = prod_sgn[POS_W+16:FRAC_W];
    sp_sum   = {{2{sp_q[POS_W-1]}}, sp_q} + {delta[POS_W], delta};
    if ($signed(sp_sum) > $signed({4'b0000, tgt_q})) sp_next = {2'b00, tgt_q};
    else if ($signed(sp_sum) < $signed(SP_MIN))      sp_next = SP_MIN[POS_W-1:0];
    else                                             sp_next = sp_sum[POS_W-1:0];
  end

  tpp_macc u_macc (
    .clk_i   (clk_i),
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .ctrl_i  (macc_ctrl),
    .acc_o   (acc)
  );

  // Payload registers of the held item and the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_i.command;
      dt_q  <= in_i.time_step;
    end
    if (emit) begin
      left_q  <= -sp_q;
      right_q <= sp_q;
      done_q  <= done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q       <= '0;
      vf_q        <= '0;
      accel_q     <= CFG_W'(65536);
      vlim_q      <= '0;
      tlim_q      <= '0;
      sp_q        <= '0;
      v_q         <= '0;
      elapsed_q   <= '0;
      speed_up_q  <= 1'b0;
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TARGET:     tgt_q   <= cfg_data_i;
          REG_FINAL_VEL:  vf_q    <= cfg_data_i;
          REG_ACCEL:      accel_q <= cfg_data_i;
          REG_VEL_LIMIT:  vlim_q  <= cfg_data_i;
          REG_TIME_LIMIT: tlim_q  <= cfg_data_i[TLIM_W-1:0];
          default: ;
        endcase
      end

      // a new result replaces the one leaving in the same cycle
      if (emit)             out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;

      if (accept) begin
        busy_q <= 1'b1;
        step_q <= '0;
        // start command: clear the profile right away
        if (!in_i.command) begin
          sp_q      <= '0;
          v_q       <= '0;
          elapsed_q <= '0;
        end
      end else if (busy_q) begin
        case (uw_cur.act)
          ACT_DECIDE: speed_up_q <= !acc[ACC_W-1] && (|acc);
          ACT_VEL:    v_q        <= v_next;
          ACT_POS: begin
            sp_q      <= sp_next;
            elapsed_q <= elapsed_q + ELAPSED_W'(dt_q);
          end
          default: ;
        endcase

        case (uw_cur.seq)
          SEQ_SKIP_IF_IDLE: step_q <= idle_item ? STEP_EMIT : step_q + STEP_W'(1);
          SEQ_END: begin
            // hold the last step until the result register is free
            if (out_free) busy_q <= 1'b0;
          end
          default: step_q <= step_q + STEP_W'(1);
        endcase
      end
    end
  end

  assign in_i.ready           = !busy_q;
  assign out_o.valid          = out_valid_q;
  assign out_o.left_position  = left_q;
  assign out_o.right_position = right_q;
  assign out_o.done_res       = done_q;
endmodule

FILE: rtl/tpp_checker.sv
// Port-level checks for the trapezoid position profile, bound to the top level.
// Depends on tpp_pkg and trapezoid_position_profile.
module tpp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [tpp_pkg::POS_W-1:0] left_pos_i,
  input logic signed [tpp_pkg::POS_W-1:0] right_pos_i,
  input logic                             done_res_i
);
  import tpp_pkg::*;

  // one item in work: a transfer closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input open right after a transfer");

  // the wheels mirror each other whenever a result is valid
  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (left_pos_i == -right_pos_i))
    else $error("left setpoint is not the negated right setpoint");

  // a new result cannot appear in the cycle right after an input transfer
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result valid one cycle after transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(right_pos_i) && $stable(done_res_i))
    else $error("stalled result changed");
endmodule

bind trapezoid_position_profile tpp_checker u_tpp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .left_pos_i  (out_o.left_position),
  .right_pos_i (out_o.right_position),
  .done_res_i  (out_o.done_res)
);
